[sv/mabb_pkg.sv]
// Shared types and constants for the alpha mask blit blend block.
package mabb_pkg;

	localparam int unsigned MAX_DIM   = 4096;
	localparam int unsigned DIM_W     = $clog2(MAX_DIM) + 1;
	localparam int unsigned POS_W     = 12;
	localparam int unsigned IDX_W     = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [7:0]  ALPHA_FULL = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AREA_X      = 3'd0,
		REG_AREA_Y      = 3'd1,
		REG_AREA_WIDTH  = 3'd2,
		REG_AREA_HEIGHT = 3'd3,
		REG_FB_WIDTH    = 3'd4,
		REG_FB_HEIGHT   = 3'd5,
		REG_FG_COLOR    = 3'd6,
		REG_DEPTH_MODE  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [12:0] area_x;
		logic signed [12:0] area_y;
		logic [12:0]        area_w;
		logic [12:0]        area_h;
		logic [DIM_W-1:0]   fb_w;   // saturated to MAX_DIM
		logic [DIM_W-1:0]   fb_h;   // saturated to MAX_DIM
		logic [31:0]        fg_color;
		logic               depth_mode;
	} cfg_t;

endpackage

[sv/mabb_regs.sv]
// Configuration register file for the alpha mask blit blend block.
module mabb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [mabb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mabb_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mabb_pkg::cfg_t                     cfg
);
	import mabb_pkg::*;

	cfg_t             cfg_q;
	logic [12:0]      dim_raw;
	logic [DIM_W-1:0] dim_sat;

	assign dim_raw = cfg_data[12:0];
	assign dim_sat = (dim_raw > 13'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(dim_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_x     <= '0;
			cfg_q.area_y     <= '0;
			cfg_q.area_w     <= 13'd1;
			cfg_q.area_h     <= 13'd1;
			cfg_q.fb_w       <= DIM_W'(1);
			cfg_q.fb_h       <= DIM_W'(1);
			cfg_q.fg_color   <= '0;
			cfg_q.depth_mode <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AREA_X:      cfg_q.area_x     <= $signed(cfg_data[12:0]);
				REG_AREA_Y:      cfg_q.area_y     <= $signed(cfg_data[12:0]);
				REG_AREA_WIDTH:  cfg_q.area_w     <= cfg_data[12:0];
				REG_AREA_HEIGHT: cfg_q.area_h     <= cfg_data[12:0];
				REG_FB_WIDTH:    cfg_q.fb_w       <= dim_sat;
				REG_FB_HEIGHT:   cfg_q.fb_h       <= dim_sat;
				REG_FG_COLOR:    cfg_q.fg_color   <= cfg_data;
				REG_DEPTH_MODE:  cfg_q.depth_mode <= cfg_data[0];
				default:         cfg_q            <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/mabb_blend.sv]
// One color channel blend: (dst*(255-a)+fg*a)>>8, or fg at full alpha.
module mabb_blend (
	input  logic [7:0] dst,
	input  logic [7:0] fg,
	input  logic [7:0] alpha,
	output logic [7:0] res
);
	import mabb_pkg::*;

	logic [15:0] dst_term;
	logic [15:0] fg_term;
	logic [15:0] sum;

	assign dst_term = 16'(dst) * 16'(ALPHA_FULL - alpha);
	assign fg_term  = 16'(fg) * 16'(alpha);
	assign sum      = dst_term + fg_term;
	assign res      = (alpha == ALPHA_FULL) ? fg : sum[15:8];

endmodule

[sv/mask_alpha_blit_blend.sv]
// Top level of the alpha mask blit blend pipeline.
//
//  channel | signals                              | role
//  --------+--------------------------------------+----------------------------
//  pix     | pix_valid/pix_ready, local_x ..     | mask pixel request in
//  res     | res_valid/res_ready, write_enable ..| pixel write result out
//  cfg     | cfg_valid/cfg_ready, cfg_index/data | register write request
//
// Four register stages: offset and coverage product, clip with divide by 255
// and row multiply, index add with channel blend, output register.
// One request per cycle unless stalled; res_valid rises as it enters stage 4.
// Each full stage holds while its successor is full and stalled, so a stall on
// res backs up into pix_ready without loss. Reset clears stage valid bits and
// loads register defaults; cfg_ready is always high.
module mask_alpha_blit_blend (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  logic [11:0]                      local_x,
	input  logic [11:0]                      local_y,
	input  logic [7:0]                       coverage,
	input  logic [7:0]                       dest_blue,
	input  logic [7:0]                       dest_green,
	input  logic [7:0]                       dest_red,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic                             write_enable,
	output logic [23:0]                      pixel_index,
	output logic [7:0]                       out_blue,
	output logic [7:0]                       out_green,
	output logic [7:0]                       out_red,
	output logic [7:0]                       out_alpha,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mabb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mabb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mabb_pkg::*;

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	mabb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage handshakes
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4      = !v_s4 || res_ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pix_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: offset, area check, coverage product
	logic signed [13:0] tx_c, ty_c;
	logic               in_area_c;
	logic [7:0]         val_c;
	logic [15:0]        prod_c;

	assign tx_c      = $signed({cfg.area_x[12], cfg.area_x}) + $signed({2'b00, local_x});
	assign ty_c      = $signed({cfg.area_y[12], cfg.area_y}) + $signed({2'b00, local_y});
	assign in_area_c = ({1'b0, local_x} < cfg.area_w) && ({1'b0, local_y} < cfg.area_h);
	assign val_c     = cfg.depth_mode ? ((coverage != 8'd0) ? ALPHA_FULL : 8'd0) : coverage;
	assign prod_c    = 16'(cfg.fg_color[31:24]) * 16'(val_c);

	logic signed [13:0] tx_s1, ty_s1;
	logic               in_area_s1;
	logic [15:0]        prod_s1;
	logic [7:0]         db_s1, dg_s1, dr_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			tx_s1      <= tx_c;
			ty_s1      <= ty_c;
			in_area_s1 <= in_area_c;
			prod_s1    <= prod_c;
			db_s1      <= dest_blue;
			dg_s1      <= dest_green;
			dr_s1      <= dest_red;
		end
	end

	// stage 2: clip, alpha = prod/255, row offset
	logic        clip_ok;
	logic [16:0] div_sum;
	logic [7:0]  alpha_c;
	logic [24:0] row_c;

	assign clip_ok = in_area_s1 && !tx_s1[13] && !ty_s1[13]
		&& (tx_s1[12:0] < cfg.fb_w) && (ty_s1[12:0] < cfg.fb_h);
	// exact x/255 for 16-bit x
	assign div_sum = {1'b0, prod_s1} + 17'd1 + {9'd0, prod_s1[15:8]};
	assign alpha_c = div_sum[15:8];
	assign row_c   = 25'(ty_s1[11:0]) * 25'(cfg.fb_w);

	logic        wr_s2;
	logic [7:0]  alpha_s2;
	logic [23:0] row_s2;
	logic [11:0] tx_s2;
	logic [7:0]  db_s2, dg_s2, dr_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			wr_s2    <= clip_ok && (alpha_c != 8'd0);
			alpha_s2 <= alpha_c;
			row_s2   <= row_c[23:0];
			tx_s2    <= tx_s1[11:0];
			db_s2    <= db_s1;
			dg_s2    <= dg_s1;
			dr_s2    <= dr_s1;
		end
	end

	// stage 3: pixel index, channel blend
	logic [7:0] bl_b, bl_g, bl_r;

	mabb_blend u_blend_b (.dst(db_s2), .fg(cfg.fg_color[7:0]),   .alpha(alpha_s2), .res(bl_b));
	mabb_blend u_blend_g (.dst(dg_s2), .fg(cfg.fg_color[15:8]),  .alpha(alpha_s2), .res(bl_g));
	mabb_blend u_blend_r (.dst(dr_s2), .fg(cfg.fg_color[23:16]), .alpha(alpha_s2), .res(bl_r));

	logic        wr_s3;
	logic [23:0] idx_s3;
	logic [7:0]  b_s3, g_s3, r_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			wr_s3  <= wr_s2;
			idx_s3 <= row_s2 + 24'(tx_s2);
			b_s3   <= bl_b;
			g_s3   <= bl_g;
			r_s3   <= bl_r;
		end
	end

	// stage 4: output register, zeroed fields when no write
	logic        wr_s4;
	logic [23:0] idx_s4;
	logic [7:0]  b_s4, g_s4, r_s4, a_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			wr_s4  <= wr_s3;
			idx_s4 <= wr_s3 ? idx_s3 : 24'd0;
			b_s4   <= wr_s3 ? b_s3 : 8'd0;
			g_s4   <= wr_s3 ? g_s3 : 8'd0;
			r_s4   <= wr_s3 ? r_s3 : 8'd0;
			a_s4   <= wr_s3 ? ALPHA_FULL : 8'd0;
		end
	end

	assign res_valid    = v_s4;
	assign write_enable = wr_s4;
	assign pixel_index  = idx_s4;
	assign out_blue     = b_s4;
	assign out_green    = g_s4;
	assign out_red      = r_s4;
	assign out_alpha    = a_s4;

endmodule

[sv/mabb_checker.sv]
// Port-level checker for the alpha mask blit blend block, with its bind.
module mabb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        write_enable,
	input logic [23:0] pixel_index,
	input logic [7:0]  out_blue,
	input logic [7:0]  out_green,
	input logic [7:0]  out_red,
	input logic [7:0]  out_alpha
);
	import mabb_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pixel_index) && $stable(write_enable))
		else $error("result request dropped or changed while stalled");

	a_alpha_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && write_enable |-> out_alpha == ALPHA_FULL)
		else $error("written pixel without full destination alpha");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !write_enable |-> pixel_index == 24'd0 && out_blue == 8'd0
			&& out_green == 8'd0 && out_red == 8'd0 && out_alpha == 8'd0)
		else $error("non-write result carries nonzero fields");

endmodule

bind mask_alpha_blit_blend mabb_checker u_mabb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.write_enable (write_enable),
	.pixel_index  (pixel_index),
	.out_blue     (out_blue),
	.out_green    (out_green),
	.out_red      (out_red),
	.out_alpha    (out_alpha)
);
